[design/ulcp_pkg.sv]
// ----------------------------------------------------------------------------
// ulcp_pkg
// Shared types, character codes and helpers for the serial line command parser.
// ----------------------------------------------------------------------------
package ulcp_pkg;

  localparam int unsigned MaxLineLength = 10;
  localparam int unsigned CountW        = 4;
  localparam int unsigned SlotCount     = 4;
  localparam int unsigned SlotIdxW      = 2;

  localparam logic [7:0] ChS       = 8'h53;
  localparam logic [7:0] ChP       = 8'h50;
  localparam logic [7:0] ChELower  = 8'h65;
  localparam logic [7:0] ChCr      = 8'h0D;
  localparam logic [7:0] ChZero    = 8'h30;
  localparam logic [7:0] HexGap    = 8'd7;
  localparam logic [7:0] HexDigMax = 8'd9;

  typedef enum logic [1:0] {
    EV_NONE      = 2'd0,
    EV_SEQ_START = 2'd1,
    EV_SEQ_STOP  = 2'd2,
    EV_OUT_SET   = 2'd3
  } frame_event_t;

  typedef logic [SlotCount-1:0][7:0] frame_slots_t;

  // what the end of a line does to the state
  typedef struct packed {
    logic         seq_set;
    logic         seq_clr;
    logic         drive_load;
    logic [7:0]   drive_value;
    frame_event_t event_code;
  } line_action_t;

  // full 8-bit digit value: 0-9 and A-F give 0-15, ':' to '@' give 3-9, other characters values above 15
  function automatic logic [7:0] hex_nibble(input logic [7:0] c);
    logic [7:0] v;
    v = c - ChZero;
    if (v > HexDigMax) begin
      v = v - HexGap;
    end
    return v;
  endfunction

endpackage

[design/ulcp_decode.sv]
// ----------------------------------------------------------------------------
// ulcp_decode
// End-of-line command decode: sequencing start/stop and hex output value.
// ----------------------------------------------------------------------------
module ulcp_decode (
  input  ulcp_pkg::frame_slots_t          slots,
  input  logic [ulcp_pkg::CountW-1:0]     count,
  input  logic                            line_end,
  output ulcp_pkg::line_action_t          action
);

  logic [7:0] hi_nib;
  logic [7:0] lo_nib;

  assign hi_nib = ulcp_pkg::hex_nibble(slots[2]);
  assign lo_nib = ulcp_pkg::hex_nibble(slots[3]);

  always_comb begin
    action             = '0;
    action.event_code  = ulcp_pkg::EV_NONE;
    // low digit is added at full width, wrapping at 8 bits
    action.drive_value = (hi_nib << 4) + lo_nib;
    if (line_end) begin
      if (count == ulcp_pkg::CountW'(2)) begin
        if (slots[0] == ulcp_pkg::ChS) begin
          action.seq_set    = 1'b1;
          action.event_code = ulcp_pkg::EV_SEQ_START;
        end else if (slots[0] == ulcp_pkg::ChP) begin
          action.seq_clr    = 1'b1;
          action.event_code = ulcp_pkg::EV_SEQ_STOP;
        end
      end else if (slots[0] == ulcp_pkg::ChS && slots[1] == ulcp_pkg::ChELower) begin
        action.drive_load = 1'b1;
        action.event_code = ulcp_pkg::EV_OUT_SET;
      end
    end
  end

endmodule

[design/uart_line_command_parser_core.sv]
// ----------------------------------------------------------------------------
// uart_line_command_parser_core
// Parses received serial bytes into line commands driving an output word.
// ----------------------------------------------------------------------------
// Usage: each byte offered on in_valid/in_ready (rx_byte) yields exactly one
// result on out_valid/out_ready carrying line_drive, sequencing_enabled and
// frame_event. A line ends on a carriage return or after 10 bytes; at the end
// the line is decoded ("S" two-byte lines start sequencing, "P" ones stop it,
// "Se" lines set the drive word from two hex digits) and frame_event reports
// what happened.
// A request is captured in the input register and decoded from there; its
// result is written to the result register when it advances, and out_valid
// then rises. Throughput: one byte per cycle while the receiver does not
// stall, set by the single decode stage between the input and result
// registers; the line state is updated as the byte moves into the result
// register.
// Reset (rst, synchronous): both registers empty, line count, stored bytes,
// drive word and sequencing flag cleared.
// Receiver stall: the result register holds; one more byte waits in the input
// register, after which in_ready drops until out_ready returns.
// ----------------------------------------------------------------------------
module uart_line_command_parser_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] line_drive,
  output logic       sequencing_enabled,
  output logic [1:0] frame_event
);

  // input register
  logic       s1_valid;
  logic [7:0] s1_byte;

  // line state
  ulcp_pkg::frame_slots_t          slots;
  ulcp_pkg::frame_slots_t          slots_next;
  logic [ulcp_pkg::CountW-1:0]     count;
  logic [ulcp_pkg::CountW-1:0]     count_next;
  logic [ulcp_pkg::CountW-1:0]     count_inc;
  logic [7:0]                      drive_word;
  logic [7:0]                      drive_word_next;
  logic                            seq_flag;
  logic                            seq_flag_next;
  logic                            line_end;
  ulcp_pkg::line_action_t          action;

  logic advance;

  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte <= rx_byte;
    end
  end

  // the count is always below the maximum at the start of a byte
  assign count_inc = count + ulcp_pkg::CountW'(1);
  assign line_end  = (s1_byte == ulcp_pkg::ChCr) ||
                     (count_inc >= ulcp_pkg::CountW'(ulcp_pkg::MaxLineLength));

  always_comb begin
    slots_next = slots;
    if (count < ulcp_pkg::CountW'(ulcp_pkg::SlotCount)) begin
      slots_next[count[ulcp_pkg::SlotIdxW-1:0]] = s1_byte;
    end
  end

  ulcp_decode u_decode (
    .slots    (slots_next),
    .count    (count_inc),
    .line_end (line_end),
    .action   (action)
  );

  always_comb begin
    count_next      = line_end ? '0 : count_inc;
    drive_word_next = action.drive_load ? action.drive_value : drive_word;
    seq_flag_next   = seq_flag;
    if (action.seq_set) begin
      seq_flag_next = 1'b1;
    end else if (action.seq_clr) begin
      seq_flag_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slots      <= '0;
      count      <= '0;
      drive_word <= '0;
      seq_flag   <= 1'b0;
    end else if (advance) begin
      slots      <= slots_next;
      count      <= count_next;
      drive_word <= drive_word_next;
      seq_flag   <= seq_flag_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      line_drive         <= drive_word_next;
      sequencing_enabled <= seq_flag_next;
      frame_event        <= action.event_code;
    end
  end

endmodule
